// ----- hdl/jdq_pkg.sv -----
// Package for the joystick D-pad qualifier: widths, register indexes and
// the item, configuration and status types shared by all modules.
// No dependencies.
`default_nettype none

package jdq_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int CAL_SHIFT   = 4;
	localparam int CAL_SAMPLES = 1 << CAL_SHIFT;
	localparam int SUM_W       = SAMPLE_BITS + CAL_SHIFT;
	localparam int CNT_W       = CAL_SHIFT;
	localparam int CFG_W       = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int KEY_W       = 4;
	localparam int DIR_W       = 4;
	localparam int CMP_W       = ((SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W) + 2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [CFG_W-1:0]       cfg_word_t;
	typedef logic [DIR_W-1:0]       dir_t;

	localparam sample_t MID_SCALE = sample_t'(1 << (SAMPLE_BITS - 1));

	localparam logic CMD_CAL  = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	// bit positions inside dir_t
	localparam int DIR_LEFT  = 0;
	localparam int DIR_RIGHT = 1;
	localparam int DIR_DOWN  = 2;
	localparam int DIR_UP    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ON_THRESHOLD  = 3'd0,
		REG_OFF_THRESHOLD = 3'd1,
		REG_MAX_DRIFT     = 3'd2,
		REG_MAX_SPREAD    = 3'd3,
		REG_SWAP_AXES     = 3'd4,
		REG_INVERT_X      = 3'd5,
		REG_INVERT_Y      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic             command;
		sample_t          x_sample;
		sample_t          y_sample;
		logic [KEY_W-1:0] button_levels;
	} in_item_t;

	typedef struct packed {
		logic left;
		logic right;
		logic down;
		logic up;
		logic start_key;
		logic a_key;
		logic b_key;
		logic select_y_key;
		logic axes_enabled;
	} out_item_t;

	typedef struct packed {
		cfg_word_t on_threshold;
		cfg_word_t off_threshold;
		cfg_word_t max_drift;
		cfg_word_t max_spread;
		logic      swap_axes;
		logic      invert_x;
		logic      invert_y;
	} cfg_t;

	typedef struct packed {
		logic axes_good;
		logic axes_good_next;
		logic round_end;
	} cal_status_t;

endpackage

`default_nettype wire

// ----- hdl/jdq_cal.sv -----
// Calibration rounds: sums, min/max per axis, round-end check and centres.
// Depends on jdq_pkg.
`default_nettype none

module jdq_cal (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  wire jdq_pkg::in_item_t     item,
	input  wire jdq_pkg::cfg_t         cfg,
	output jdq_pkg::sample_t           center_x,
	output jdq_pkg::sample_t           center_y,
	output jdq_pkg::cal_status_t       status
);
	import jdq_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_x_q, sum_y_q;
	sample_t          low_x_q, high_x_q, low_y_q, high_y_q;
	sample_t          center_x_q, center_y_q;
	logic             axes_good_q;

	logic [SUM_W-1:0] sum_x_nxt, sum_y_nxt;
	sample_t          low_x_nxt, high_x_nxt, low_y_nxt, high_y_nxt;
	sample_t          avg_x, avg_y;
	sample_t          drift_x, drift_y, spread_x, spread_y;
	logic             is_cal, last, ok, cal_step;

	assign is_cal   = (item.command == CMD_CAL);
	assign cal_step = step && is_cal;
	assign last     = (cnt_q == CNT_W'(CAL_SAMPLES - 1));

	assign sum_x_nxt  = sum_x_q + SUM_W'(item.x_sample);
	assign sum_y_nxt  = sum_y_q + SUM_W'(item.y_sample);
	assign low_x_nxt  = (item.x_sample < low_x_q)  ? item.x_sample : low_x_q;
	assign high_x_nxt = (item.x_sample > high_x_q) ? item.x_sample : high_x_q;
	assign low_y_nxt  = (item.y_sample < low_y_q)  ? item.y_sample : low_y_q;
	assign high_y_nxt = (item.y_sample > high_y_q) ? item.y_sample : high_y_q;

	// truncating average over a power-of-two round
	assign avg_x = sum_x_nxt[SUM_W-1:CAL_SHIFT];
	assign avg_y = sum_y_nxt[SUM_W-1:CAL_SHIFT];

	assign drift_x  = (avg_x >= MID_SCALE) ? avg_x - MID_SCALE : MID_SCALE - avg_x;
	assign drift_y  = (avg_y >= MID_SCALE) ? avg_y - MID_SCALE : MID_SCALE - avg_y;
	assign spread_x = high_x_nxt - low_x_nxt;
	assign spread_y = high_y_nxt - low_y_nxt;

	assign ok = (CMP_W'(drift_x)  <= CMP_W'(cfg.max_drift))  &&
	            (CMP_W'(drift_y)  <= CMP_W'(cfg.max_drift))  &&
	            (CMP_W'(spread_x) <= CMP_W'(cfg.max_spread)) &&
	            (CMP_W'(spread_y) <= CMP_W'(cfg.max_spread));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			low_x_q     <= '1;
			low_y_q     <= '1;
			high_x_q    <= '0;
			high_y_q    <= '0;
			center_x_q  <= MID_SCALE;
			center_y_q  <= MID_SCALE;
			axes_good_q <= 1'b0;
		end else if (cal_step) begin
			if (last) begin
				cnt_q       <= '0;
				sum_x_q     <= '0;
				sum_y_q     <= '0;
				low_x_q     <= '1;
				low_y_q     <= '1;
				high_x_q    <= '0;
				high_y_q    <= '0;
				axes_good_q <= ok;
				if (ok) begin
					center_x_q <= avg_x;
					center_y_q <= avg_y;
				end
			end else begin
				cnt_q    <= cnt_q + 1'b1;
				sum_x_q  <= sum_x_nxt;
				sum_y_q  <= sum_y_nxt;
				low_x_q  <= low_x_nxt;
				low_y_q  <= low_y_nxt;
				high_x_q <= high_x_nxt;
				high_y_q <= high_y_nxt;
			end
		end
	end

	assign center_x              = center_x_q;
	assign center_y              = center_y_q;
	assign status.axes_good      = axes_good_q;
	assign status.round_end      = cal_step && last;
	assign status.axes_good_next = (cal_step && last) ? ok : axes_good_q;

endmodule

`default_nettype wire

// ----- hdl/jdq_dir.sv -----
// Direction qualifier: swap, invert, deadzone with hysteresis, held state.
// Depends on jdq_pkg.
`default_nettype none

module jdq_dir (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  wire jdq_pkg::in_item_t     item,
	input  wire jdq_pkg::cfg_t         cfg,
	input  wire jdq_pkg::sample_t      center_x,
	input  wire jdq_pkg::sample_t      center_y,
	input  wire jdq_pkg::cal_status_t  status,
	output jdq_pkg::dir_t              dir
);
	import jdq_pkg::*;

	typedef logic signed [CMP_W-1:0] offs_t;

	dir_t    held_q;
	dir_t    dir_c;
	sample_t vx, vy, cx, cy;
	offs_t   dx, dy, dx_i, dy_i;
	logic    active;

	// returns {pos, neg}; negative side wins
	function automatic logic [1:0] qualify(input offs_t d, input logic held_neg,
	                                       input logic held_pos, input cfg_t c);
		offs_t tn, tp;
		tn = offs_t'(held_neg ? c.off_threshold : c.on_threshold);
		tp = offs_t'(held_pos ? c.off_threshold : c.on_threshold);
		if (d + tn <= offs_t'(0)) begin
			qualify = 2'b01;
		end else if (d >= tp) begin
			qualify = 2'b10;
		end else begin
			qualify = 2'b00;
		end
	endfunction

	assign active = (item.command == CMD_POLL) && status.axes_good;

	assign vx = cfg.swap_axes ? item.y_sample : item.x_sample;
	assign vy = cfg.swap_axes ? item.x_sample : item.y_sample;
	assign cx = cfg.swap_axes ? center_y : center_x;
	assign cy = cfg.swap_axes ? center_x : center_y;

	assign dx   = offs_t'(vx) - offs_t'(cx);
	assign dy   = offs_t'(vy) - offs_t'(cy);
	assign dx_i = cfg.invert_x ? -dx : dx;
	assign dy_i = cfg.invert_y ? -dy : dy;

	always_comb begin
		dir_c = '0;
		if (active) begin
			{dir_c[DIR_RIGHT], dir_c[DIR_LEFT]} =
				qualify(dx_i, held_q[DIR_LEFT], held_q[DIR_RIGHT], cfg);
			{dir_c[DIR_UP], dir_c[DIR_DOWN]} =
				qualify(dy_i, held_q[DIR_DOWN], held_q[DIR_UP], cfg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (step) begin
			if (status.round_end) begin
				held_q <= '0;
			end else if (active) begin
				held_q <= dir_c;
			end
		end
	end

	assign dir = dir_c;

endmodule

`default_nettype wire

// ----- hdl/joystick_dpad_qualifier.sv -----
// Top level of the joystick D-pad qualifier: configuration registers,
// input register and result register. Depends on jdq_pkg, jdq_cal, jdq_dir.
//
// One result per item, one item per cycle sustained while out_ready holds;
// each item waits in the input register, its result in the result register,
// and the calibration/hysteresis state updates as the item leaves the input
// register. The input side stalls only while a result is held in the result
// register with another item waiting behind it. Configuration writes (index
// 0..6, others ignored) are always taken and must only be made while idle.
`default_nettype none

module joystick_dpad_qualifier (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire jdq_pkg::in_item_t      in_item,
	output logic                        out_valid,
	input  wire                         out_ready,
	output jdq_pkg::out_item_t          out_item,
	input  wire                         cfg_valid,
	output logic                        cfg_ready,
	input  wire [jdq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire jdq_pkg::cfg_word_t     cfg_data
);
	import jdq_pkg::*;

	cfg_t        cfg_q;
	in_item_t    item_s1;
	logic        valid_s1;
	out_item_t   out_q;
	logic        out_valid_q;
	logic        advance;
	sample_t     center_x, center_y;
	cal_status_t cal_status;
	dir_t        dir;
	out_item_t   result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_threshold  <= cfg_word_t'(700);
			cfg_q.off_threshold <= cfg_word_t'(450);
			cfg_q.max_drift     <= cfg_word_t'(600);
			cfg_q.max_spread    <= cfg_word_t'(300);
			cfg_q.swap_axes     <= 1'b0;
			cfg_q.invert_x      <= 1'b0;
			cfg_q.invert_y      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ON_THRESHOLD:  cfg_q.on_threshold  <= cfg_data;
				REG_OFF_THRESHOLD: cfg_q.off_threshold <= cfg_data;
				REG_MAX_DRIFT:     cfg_q.max_drift     <= cfg_data;
				REG_MAX_SPREAD:    cfg_q.max_spread    <= cfg_data;
				REG_SWAP_AXES:     cfg_q.swap_axes     <= cfg_data[0];
				REG_INVERT_X:      cfg_q.invert_x      <= cfg_data[0];
				REG_INVERT_Y:      cfg_q.invert_y      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	jdq_cal u_cal (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.cfg      (cfg_q),
		.center_x (center_x),
		.center_y (center_y),
		.status   (cal_status)
	);

	jdq_dir u_dir (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.cfg      (cfg_q),
		.center_x (center_x),
		.center_y (center_y),
		.status   (cal_status),
		.dir      (dir)
	);

	always_comb begin
		result.left         = dir[DIR_LEFT];
		result.right        = dir[DIR_RIGHT];
		result.down         = dir[DIR_DOWN];
		result.up           = dir[DIR_UP];
		result.start_key    = !item_s1.button_levels[0];
		result.a_key        = !item_s1.button_levels[1];
		result.b_key        = !item_s1.button_levels[2];
		result.select_y_key = !item_s1.button_levels[3];
		result.axes_enabled = cal_status.axes_good_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ----- hdl/jdq_checker.sv -----
// Port-level checks for joystick_dpad_qualifier, bound to the top level.
// Depends on jdq_pkg and joystick_dpad_qualifier.
`default_nettype none

module jdq_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     in_ready,
	input wire                     out_valid,
	input wire                     out_ready,
	input wire jdq_pkg::out_item_t out_item
);

	// a pending result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// input stalls only behind a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	a_one_per_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.left && out_item.right) &&
		              !(out_item.down && out_item.up))
		else $error("both directions of one axis active");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.axes_enabled |->
			!(out_item.left || out_item.right || out_item.down || out_item.up))
		else $error("direction reported with axes disabled");

endmodule

bind joystick_dpad_qualifier jdq_checker u_jdq_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for joystick_dpad_qualifier: bursty random and directed joystick items
// against a cycle-free predictor of calibration, deadzone and key decoding.
// Depends on jdq_pkg and the joystick_dpad_qualifier RTL.
`default_nettype none

module tb;
	import jdq_pkg::*;

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_EVERY_FOURTH, RDY_LONG_STALLS} ready_mode_e;

	localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = 3'd7;
	localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	cfg_word_t cfg_data = '0;

	joystick_dpad_qualifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the registers and state
	cfg_word_t on_thr = 12'd700;
	cfg_word_t off_thr = 12'd450;
	cfg_word_t drift_limit = 12'd600;
	cfg_word_t spread_limit = 12'd300;
	logic swap_xy = 1'b0;
	logic flip_x = 1'b0;
	logic flip_y = 1'b0;

	sample_t centre_x = MID_SCALE;
	sample_t centre_y = MID_SCALE;
	logic axes_ok = 1'b0;
	dir_t held_dirs = '0;
	logic [4:0] round_count = '0;
	logic [15:0] acc_x = '0;
	logic [15:0] acc_y = '0;
	logic [12:0] min_x = 13'd4096;
	logic [12:0] max_x = '1;
	logic [12:0] min_y = 13'd4096;
	logic [12:0] max_y = '1;

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int queued_items = 0;

	// {pos, neg} for one axis with hysteresis on the held bits
	function automatic logic [1:0] qualify_axis(int d, logic held_neg, logic held_pos);
		int tn;
		int tp;
		tn = held_neg ? int'(off_thr) : int'(on_thr);
		tp = held_pos ? int'(off_thr) : int'(on_thr);
		if (d <= -tn)
			return 2'b01;
		if (d >= tp)
			return 2'b10;
		return 2'b00;
	endfunction

	function automatic out_item_t predict_result(in_item_t it);
		out_item_t r;
		dir_t dir;
		int vx, vy, cx, cy, dx, dy, ax, ay, mid;
		logic [1:0] hq, vq;
		logic pass;
		dir = '0;
		mid = int'(MID_SCALE);
		if (it.command == CMD_CAL) begin
			acc_x = acc_x + 16'(it.x_sample);
			acc_y = acc_y + 16'(it.y_sample);
			if (round_count == 0 || 13'(it.x_sample) < min_x) min_x = 13'(it.x_sample);
			if (round_count == 0 || 13'(it.x_sample) > max_x) max_x = 13'(it.x_sample);
			if (round_count == 0 || 13'(it.y_sample) < min_y) min_y = 13'(it.y_sample);
			if (round_count == 0 || 13'(it.y_sample) > max_y) max_y = 13'(it.y_sample);
			round_count = round_count + 1'b1;
			if (round_count >= CAL_SAMPLES) begin
				ax = int'(acc_x) / CAL_SAMPLES;
				ay = int'(acc_y) / CAL_SAMPLES;
				pass = ((ax >= mid) ? ax - mid : mid - ax) <= int'(drift_limit) &&
					((ay >= mid) ? ay - mid : mid - ay) <= int'(drift_limit) &&
					int'(max_x) - int'(min_x) <= int'(spread_limit) &&
					int'(max_y) - int'(min_y) <= int'(spread_limit);
				if (pass) begin
					centre_x = sample_t'(ax);
					centre_y = sample_t'(ay);
				end
				axes_ok = pass;
				held_dirs = '0;
				round_count = '0;
				acc_x = '0;
				acc_y = '0;
				min_x = 13'd4096;
				min_y = 13'd4096;
				max_x = '1;
				max_y = '1;
			end
		end else if (axes_ok) begin
			vx = swap_xy ? int'(it.y_sample) : int'(it.x_sample);
			vy = swap_xy ? int'(it.x_sample) : int'(it.y_sample);
			cx = swap_xy ? int'(centre_y) : int'(centre_x);
			cy = swap_xy ? int'(centre_x) : int'(centre_y);
			dx = flip_x ? cx - vx : vx - cx;
			dy = flip_y ? cy - vy : vy - cy;
			hq = qualify_axis(dx, held_dirs[DIR_LEFT], held_dirs[DIR_RIGHT]);
			vq = qualify_axis(dy, held_dirs[DIR_DOWN], held_dirs[DIR_UP]);
			dir[DIR_LEFT] = hq[0];
			dir[DIR_RIGHT] = hq[1];
			dir[DIR_DOWN] = vq[0];
			dir[DIR_UP] = vq[1];
			held_dirs = dir;
		end
		r.left = dir[DIR_LEFT];
		r.right = dir[DIR_RIGHT];
		r.down = dir[DIR_DOWN];
		r.up = dir[DIR_UP];
		r.start_key = ~it.button_levels[0];
		r.a_key = ~it.button_levels[1];
		r.b_key = ~it.button_levels[2];
		r.select_y_key = ~it.button_levels[3];
		r.axes_enabled = axes_ok;
		return r;
	endfunction

	function automatic string field_label(int k);
		case (k)
			0: return "left";
			1: return "right";
			2: return "down";
			3: return "up";
			4: return "start_key";
			5: return "a_key";
			6: return "b_key";
			7: return "select_y_key";
			default: return "axes_enabled";
		endcase
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// sender: bursts of random length, random gaps between them
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				in_valid <= 1'b1;
				in_item <= pending_items.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern
	ready_mode_e ready_mode = RDY_ALWAYS;
	int mode_left = 0;
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= ready_mode_e'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				RDY_ALWAYS: out_ready <= 1'b1;
				RDY_COIN: out_ready <= 1'($urandom_range(0, 1));
				RDY_EVERY_FOURTH: out_ready <= (mode_left % 4) == 0;
				default: begin
					if (stall_left > 0) begin
						out_ready <= 1'b0;
						stall_left <= stall_left - 1;
					end else begin
						out_ready <= 1'b1;
						if ($urandom_range(0, 3) == 0)
							stall_left <= $urandom_range(5, 16);
					end
				end
			endcase
		end
	end

	// input transfers feed the predictor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			expected_results.push_back(predict_result(in_item));
	end

	// result transfers against the oldest expectation
	always @(posedge clk) begin : result_check
		out_item_t want;
		int k;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
			end else begin
				want = expected_results.pop_front();
				for (k = 0; k < $bits(out_item_t); k++)
					if (out_item[$bits(out_item_t)-1-k] !== want[$bits(out_item_t)-1-k])
						report_mismatch($sformatf("result %0d: %s is %b, expected %b",
							results_seen, field_label(k),
							out_item[$bits(out_item_t)-1-k], want[$bits(out_item_t)-1-k]));
			end
			results_seen++;
		end
	end

	function automatic sample_t to_sample(int v);
		if (v < 0)
			return '0;
		if (v > SAMPLE_MAX)
			return sample_t'(SAMPLE_MAX);
		return sample_t'(v);
	endfunction

	function automatic int signed_rand(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic queue_item(logic cmd, int x, int y, int levels);
		in_item_t it;
		it.command = cmd;
		it.x_sample = to_sample(x);
		it.y_sample = to_sample(y);
		it.button_levels = 4'(levels);
		pending_items.push_back(it);
		queued_items++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, cfg_word_t value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_ON_THRESHOLD: on_thr = value;
			REG_OFF_THRESHOLD: off_thr = value;
			REG_MAX_DRIFT: drift_limit = value;
			REG_MAX_SPREAD: spread_limit = value;
			REG_SWAP_AXES: swap_xy = value[0];
			REG_INVERT_X: flip_x = value[0];
			REG_INVERT_Y: flip_y = value[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(int on, int off, int drift, int spread, int swp, int ix, int iy);
		write_reg(REG_ON_THRESHOLD, cfg_word_t'(on));
		write_reg(REG_OFF_THRESHOLD, cfg_word_t'(off));
		write_reg(REG_MAX_DRIFT, cfg_word_t'(drift));
		write_reg(REG_MAX_SPREAD, cfg_word_t'(spread));
		write_reg(REG_SWAP_AXES, cfg_word_t'(swp));
		write_reg(REG_INVERT_X, cfg_word_t'(ix));
		write_reg(REG_INVERT_Y, cfg_word_t'(iy));
	endtask

	task automatic randomise_config();
		int on;
		int off;
		on = $urandom_range(0, 1500);
		off = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, on);
		set_config(on, off,
			($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(200, 1200),
			($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095) : $urandom_range(100, 800),
			$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	// holds the test flow until every item is sent and every result is back
	task automatic wait_for_idle();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// pad a partly filled round so that directed rounds line up
	task automatic close_open_round();
		int i;
		if (round_count != 0)
			for (i = round_count; i < CAL_SAMPLES; i++)
				queue_item(CMD_CAL, int'(MID_SCALE), int'(MID_SCALE), $urandom_range(0, 15));
	endtask

	task automatic add_cal_round(int count);
		int cx, cy, spread, i;
		cx = int'(MID_SCALE) + signed_rand(($urandom_range(0, 3) == 0) ? 2000 : 700);
		cy = int'(MID_SCALE) + signed_rand(($urandom_range(0, 3) == 0) ? 2000 : 700);
		spread = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 300);
		for (i = 0; i < count; i++)
			queue_item(CMD_CAL, cx + signed_rand(spread / 2), cy + signed_rand(spread / 2),
				$urandom_range(0, 15));
	endtask

	// polls that walk the stick across the thresholds and back
	task automatic add_sweep(int count);
		int x, y, sx, sy, i;
		x = int'(MID_SCALE) + signed_rand(1500);
		y = int'(MID_SCALE) + signed_rand(1500);
		sx = signed_rand(200);
		sy = signed_rand(200);
		for (i = 0; i < count; i++) begin
			queue_item(CMD_POLL, x, y, $urandom_range(0, 15));
			x = x + sx;
			y = y + sy;
			if ($urandom_range(0, 5) == 0 || x < 0 || x > SAMPLE_MAX) sx = -sx;
			if ($urandom_range(0, 5) == 0 || y < 0 || y > SAMPLE_MAX) sy = -sy;
		end
	endtask

	task automatic fill_random(int count);
		int target;
		int i;
		int pick;
		target = queued_items + count;
		while (queued_items < target) begin
			pick = $urandom_range(0, 9);
			if (pick <= 2)
				add_cal_round(CAL_SAMPLES);
			else if (pick == 3)
				add_cal_round($urandom_range(1, CAL_SAMPLES - 1));
			else if (pick <= 7)
				add_sweep($urandom_range(8, 30));
			else
				for (i = $urandom_range(1, 6); i > 0; i--)
					queue_item($urandom_range(0, 1), $urandom_range(0, SAMPLE_MAX),
						$urandom_range(0, SAMPLE_MAX), $urandom_range(0, 15));
		end
	endtask

	initial begin
		int i;
		int phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: polls before calibration, a good round, then hysteresis
		queue_item(CMD_POLL, 0, SAMPLE_MAX, 4'b0000);
		queue_item(CMD_POLL, SAMPLE_MAX, 0, 4'b1111);
		for (i = 0; i < CAL_SAMPLES; i++)
			queue_item(CMD_CAL, 2098 + 4 * i, 1990 - 3 * i, i);
		queue_item(CMD_POLL, 0, 1967, 4'b0101);
		queue_item(CMD_POLL, 1650, 1967, 4'b1010);
		queue_item(CMD_POLL, 1800, 1967, 4'b0011);
		queue_item(CMD_POLL, SAMPLE_MAX, 1967, 4'b1100);
		queue_item(CMD_POLL, 2128, 0, 4'b0110);
		queue_item(CMD_POLL, 2128, SAMPLE_MAX, 4'b1001);
		queue_item(CMD_POLL, 2128, 1967, 4'b1110);
		wait_for_idle();

		randomise_config();
		write_reg(UNUSED_REG_INDEX, cfg_word_t'($urandom_range(0, SAMPLE_MAX)));
		fill_random(70);
		wait_for_idle();

		// zero thresholds, anything calibrates, swap and both inversions
		set_config(0, 0, SAMPLE_MAX, SAMPLE_MAX, 1, 1, 1);
		close_open_round();
		for (i = 0; i < CAL_SAMPLES; i++)
			queue_item(CMD_CAL, 1000, 3000, $urandom_range(0, 15));
		queue_item(CMD_POLL, 3000, 1000, 4'b0000);
		queue_item(CMD_POLL, 1000, 3000, 4'b1111);
		fill_random(60);
		wait_for_idle();

		// widest thresholds, no drift or spread allowed
		set_config(SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0, 0, 0);
		close_open_round();
		for (i = 0; i < CAL_SAMPLES; i++)
			queue_item(CMD_CAL, int'(MID_SCALE), int'(MID_SCALE), $urandom_range(0, 15));
		queue_item(CMD_POLL, 0, SAMPLE_MAX, 4'b0000);
		queue_item(CMD_POLL, SAMPLE_MAX, 0, 4'b1111);
		for (i = 0; i < CAL_SAMPLES; i++)
			queue_item(CMD_CAL, int'(MID_SCALE) + ((i == 5) ? 1 : 0), int'(MID_SCALE), i);
		queue_item(CMD_POLL, 0, 0, 4'b1010);
		fill_random(40);
		wait_for_idle();

		for (phase = 0; phase < 4; phase++) begin
			randomise_config();
			fill_random(70);
			wait_for_idle();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/jdq_pkg.sv
hdl/jdq_cal.sv
hdl/jdq_dir.sv
hdl/joystick_dpad_qualifier.sv
hdl/jdq_checker.sv
sim/tb.sv
